// File: rtl/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types, character codes and sizes of the command tokenizer.
// ----------------------------------------------------------------------------
package rct_pkg;

  // number widths of the array header and element lengths
  localparam int CountWidth  = 16;
  localparam int LengthWidth = 32;
  localparam int AccWidth    = (LengthWidth > CountWidth) ? LengthWidth : CountWidth;
  // accum * 10 + digit needs four more bits
  localparam int ProdWidth   = AccWidth + 4;

  localparam int IndexWidth  = 16;
  localparam int MaxResults  = 3;

  // result queue
  localparam int FifoDepth   = 4;
  localparam int PtrWidth    = $clog2(FifoDepth);
  localparam int FillWidth   = $clog2(FifoDepth + 1);

  // character codes
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [3:0] {
    PH_START,
    PH_INLINE,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_PAYLOAD,
    PH_SKIP1,
    PH_SKIP2,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_DOLLAR   = 3'd1,
    ERR_NUMBER   = 3'd2,
    ERR_TRUNC    = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_e;

  // one output item
  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            data;
    logic [IndexWidth-1:0] token_index;
    err_e                  error_code;
    logic                  run_last;
  } res_t;

  // all results caused by one input byte, packed from slot 0 up
  typedef struct packed {
    res_t [MaxResults-1:0] item;
    logic [1:0]            cnt;
  } res_bundle_t;

endpackage

// File: rtl/rct_parser.sv
// ----------------------------------------------------------------------------
// rct_parser
// Parse state registers and the per-byte decode that yields up to three
// results for each accepted byte.
// ----------------------------------------------------------------------------
module rct_parser import rct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output res_bundle_t bundle_o
);

  phase_e                 phase_q, phase_d;
  logic [CountWidth-1:0]  elements_q, elements_d;
  logic [LengthWidth-1:0] payload_q, payload_d;
  logic [AccWidth-1:0]    acc_q, acc_d;
  logic                   digit_q, digit_d;
  logic                   open_q, open_d;
  logic [IndexWidth-1:0]  count_q, count_d;
  err_e                   err_q, err_d;

  phase_e                 ph_eff;
  logic                   skip_star;
  logic                   is_space, is_digit;
  logic [ProdWidth-1:0]   acc_next;
  logic                   ovf;
  logic                   end_elem;
  logic                   emit_byte, emit_end, emit_status;
  kind_e                  status_kind;
  err_e                   status_code;
  logic [IndexWidth-1:0]  status_index;
  res_t                   rec_byte, rec_end, rec_status;
  logic [1:0]             n;

  assign is_space = (byte_i == ChSpace) || ((byte_i >= ChTab) && (byte_i <= ChCr));
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign acc_next = (ProdWidth'(acc_q) << 3) + (ProdWidth'(acc_q) << 1)
                  + ProdWidth'(byte_i - ChZero);

  always_comb begin
    phase_d      = phase_q;
    elements_d   = elements_q;
    payload_d    = payload_q;
    acc_d        = acc_q;
    digit_d      = digit_q;
    open_d       = open_q;
    count_d      = count_q;
    err_d        = err_q;
    end_elem     = 1'b0;
    emit_byte    = 1'b0;
    emit_end     = 1'b0;
    emit_status  = 1'b0;
    status_kind  = KIND_OK;
    status_code  = ERR_NONE;
    status_index = '0;
    ovf          = 1'b0;

    if (phase_q == PH_START) begin
      ph_eff = (byte_i == ChStar) ? PH_COUNT : PH_INLINE;
    end else begin
      ph_eff = phase_q;
    end
    phase_d = ph_eff;

    // leading star bytes before any digit are swallowed
    skip_star = (ph_eff == PH_COUNT) && (byte_i == ChStar) && !digit_q && (acc_q == '0);

    if (!skip_star) begin
      case (ph_eff)
        PH_INLINE: begin
          if (is_space) begin
            if (open_q) begin
              emit_end = 1'b1;
              count_d  = count_q + 1'b1;
              open_d   = 1'b0;
            end
          end else begin
            emit_byte = 1'b1;
            open_d    = 1'b1;
          end
        end
        PH_COUNT, PH_LEN: begin
          if (ph_eff == PH_COUNT) begin
            ovf = |(acc_next >> CountWidth);
          end else begin
            ovf = |(acc_next >> LengthWidth);
          end
          if (byte_i == ChCr) begin
            if (digit_q) begin
              phase_d = (ph_eff == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
            end else begin
              err_d   = ERR_NUMBER;
              phase_d = PH_ERROR;
            end
          end else if (!is_digit) begin
            err_d   = ERR_NUMBER;
            phase_d = PH_ERROR;
          end else if (ovf) begin
            err_d   = ERR_OVERFLOW;
            phase_d = PH_ERROR;
          end else begin
            acc_d   = acc_next[AccWidth-1:0];
            digit_d = 1'b1;
          end
        end
        PH_COUNT_LF: begin
          if (byte_i != ChLf) begin
            err_d   = ERR_NUMBER;
            phase_d = PH_ERROR;
          end else begin
            elements_d = acc_q[CountWidth-1:0];
            acc_d      = '0;
            digit_d    = 1'b0;
            phase_d    = (acc_q == '0) ? PH_DONE : PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (byte_i == ChDollar) begin
            phase_d = PH_LEN;
          end else begin
            err_d   = ERR_DOLLAR;
            phase_d = PH_ERROR;
          end
        end
        PH_LEN_LF: begin
          if (byte_i != ChLf) begin
            err_d   = ERR_NUMBER;
            phase_d = PH_ERROR;
          end else begin
            payload_d = acc_q[LengthWidth-1:0];
            acc_d     = '0;
            digit_d   = 1'b0;
            if (acc_q == '0) begin
              end_elem = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          emit_byte = 1'b1;
          open_d    = 1'b1;
          payload_d = payload_q - 1'b1;
          if (payload_q == LengthWidth'(1)) begin
            end_elem = 1'b1;
          end
        end
        PH_SKIP1: begin
          phase_d = PH_SKIP2;
        end
        PH_SKIP2: begin
          phase_d = PH_DOLLAR;
        end
        default: begin
        end
      endcase
    end

    if (end_elem) begin
      emit_end   = 1'b1;
      count_d    = count_q + 1'b1;
      open_d     = 1'b0;
      elements_d = elements_q - 1'b1;
      phase_d    = (elements_q == CountWidth'(1)) ? PH_DONE : PH_SKIP1;
    end

    if (last_i) begin
      emit_status = 1'b1;
      if (err_d != ERR_NONE) begin
        status_kind = KIND_ERR;
        status_code = err_d;
      end else if (phase_d == PH_INLINE) begin
        // close an open inline token before the status
        if (open_d) begin
          emit_end = 1'b1;
          count_d  = count_d + 1'b1;
        end
      end else if (phase_d != PH_DONE) begin
        status_kind = KIND_ERR;
        status_code = ERR_TRUNC;
      end
      status_index = count_d;
      phase_d    = PH_START;
      elements_d = '0;
      payload_d  = '0;
      acc_d      = '0;
      digit_d    = 1'b0;
      open_d     = 1'b0;
      count_d    = '0;
      err_d      = ERR_NONE;
    end
  end

  always_comb begin
    rec_byte   = '{kind: KIND_BYTE, data: byte_i, token_index: count_q,
                   error_code: ERR_NONE, run_last: 1'b0};
    rec_end    = '{kind: KIND_END, data: 8'h00, token_index: count_q,
                   error_code: ERR_NONE, run_last: 1'b0};
    rec_status = '{kind: status_kind, data: 8'h00, token_index: status_index,
                   error_code: status_code, run_last: 1'b0};
    bundle_o.item = '0;
    n = '0;
    if (emit_byte) begin
      bundle_o.item[n] = rec_byte;
      n = n + 1'b1;
    end
    if (emit_end) begin
      bundle_o.item[n] = rec_end;
      n = n + 1'b1;
    end
    if (emit_status) begin
      bundle_o.item[n] = rec_status;
      n = n + 1'b1;
    end
    if (n != '0) begin
      bundle_o.item[n - 1'b1].run_last = 1'b1;
    end
    bundle_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      elements_q <= '0;
      payload_q  <= '0;
      acc_q      <= '0;
      digit_q    <= 1'b0;
      open_q     <= 1'b0;
      count_q    <= '0;
      err_q      <= ERR_NONE;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      elements_q <= elements_d;
      payload_q  <= payload_d;
      acc_q      <= acc_d;
      digit_q    <= digit_d;
      open_q     <= open_d;
      count_q    <= count_d;
      err_q      <= err_d;
    end
  end

endmodule

// File: rtl/rct_result_fifo.sv
// ----------------------------------------------------------------------------
// rct_result_fifo
// Small result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
module rct_result_fifo import rct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  res_bundle_t bundle_i,
  input  logic        pop_i,
  output logic        space_o,
  output logic        valid_o,
  output res_t        head_o
);

  res_t                 mem_q [FifoDepth];
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillWidth-1:0] fill_q, fill_d;
  logic [FillWidth-1:0] n_push;
  logic                 do_pop;

  assign valid_o = (fill_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign space_o = (fill_q <= FillWidth'(FifoDepth - MaxResults));
  assign head_o  = mem_q[rd_ptr_q];
  assign n_push  = push_i ? FillWidth'(bundle_i.cnt) : '0;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrWidth'(n_push);
    rd_ptr_d = rd_ptr_q + PtrWidth'(do_pop);
    fill_d   = fill_q + n_push - FillWidth'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (push_i && (i < int'(bundle_i.cnt))) begin
        mem_q[wr_ptr_q + PtrWidth'(i)] <= bundle_i.item[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// File: rtl/resp_command_tokenizer_core.sv
// ----------------------------------------------------------------------------
// resp_command_tokenizer_core
// Byte-stream tokenizer for command messages in array or inline form.
// ----------------------------------------------------------------------------
// usage
//   slave stream: one message byte per request, tlast on the final byte.
//   a message starting with '*' is read as an array of length-prefixed
//   elements, anything else is split on whitespace
//   master stream: one result per request; tuser gives the kind (token
//   byte, token end, message ok, message error), tdata carries the byte,
//   token index and error code, tlast marks the last result of a byte
// result timing and throughput
//   results of a byte show on the master side in the cycle after it is taken
//   when the result queue is empty, else behind the results already queued
//   one byte per cycle is taken while the result queue has room for three
//   results; the master side drains one result per cycle while tready is high, so
//   the sustained rate is one byte per cycle when each byte gives at most one
//   result and is set by the master side otherwise
// reset
//   parse state returns to start of message and the result queue empties
// stall
//   a stalled master holds its result; the queue fills and tready drops
//   once fewer than three entries are free
// ----------------------------------------------------------------------------
module resp_command_tokenizer_core import rct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // msg_last
  // master result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data, [23:8] token_index,
                                      // [26:24] error_code, [31:27] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // run_last
);

  logic        accept;
  res_bundle_t bundle;
  res_t        head;

  // a byte is taken only when the queue can hold all its results
  assign accept = s_axis_tvalid && s_axis_tready;

  rct_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .bundle_o (bundle)
  );

  rct_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .bundle_i (bundle),
    .pop_i    (m_axis_tready),
    .space_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .head_o   (head)
  );

  // pack the result onto the master ports
  assign m_axis_tdata = {5'b0, head.error_code, head.token_index, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.run_last;

endmodule

// File: rtl/rct_checker.sv
// ----------------------------------------------------------------------------
// rct_checker
// Port-level checks of the tokenizer result stream.
// ----------------------------------------------------------------------------
module rct_checker import rct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a message status is always the last result of its byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_OK || m_axis_tuser == KIND_ERR)
      |-> m_axis_tlast)
    else $error("status not last of its byte");

  // error code only on an error status
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_ERR |-> m_axis_tdata[26:24] == ERR_NONE)
    else $error("error code outside error status");

  // data byte only on a token byte
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tdata[7:0] == 8'h00)
    else $error("data set outside token byte");

endmodule

bind resp_command_tokenizer_core rct_checker u_rct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command tokenizer: directed array, error and
// inline messages, then random well-formed, broken and noisy messages with
// random source gaps and sink stalls, every result checked against a
// cycle-free model of the parser.
// ----------------------------------------------------------------------------
module testbench;
  import rct_pkg::*;

  localparam int RandomItems = 370;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 400000;
  localparam int PrintCap    = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] byte_in
  logic        s_axis_tlast = 1'b0;   // msg_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [7:0] data, [23:8] token_index,
                                      // [26:24] error_code, [31:27] zero
  logic [1:0]  m_axis_tuser;          // [1:0] kind
  logic        m_axis_tlast;          // run_last

  resp_command_tokenizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // parser model: counts kept in 64-bit fields so overflow is seen exactly
  // --------------------------------------------------------------------------
  phase_e      ph_q;
  logic [63:0] elems_q;
  logic [63:0] payload_q;
  logic [63:0] accum_q;
  bit          digits_q;
  bit          open_q;
  logic [15:0] tokens_q;
  err_e        err_q;

  res_t        step_res [MaxResults];
  int          step_n;
  res_t        pending_results [$];

  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  msg_bytes [$];

  function automatic void clear_parse();
    ph_q      = PH_START;
    elems_q   = '0;
    payload_q = '0;
    accum_q   = '0;
    digits_q  = 1'b0;
    open_q    = 1'b0;
    tokens_q  = '0;
    err_q     = ERR_NONE;
  endfunction

  function automatic void add_result(kind_e k, logic [7:0] d, err_e e);
    if (step_n < MaxResults) begin
      step_res[step_n] = '{kind: k, data: d, token_index: tokens_q, error_code: e,
                           run_last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void close_token();
    add_result(KIND_END, 8'd0, ERR_NONE);
    tokens_q = tokens_q + 16'd1;
    open_q   = 1'b0;
  endfunction

  function automatic void close_element();
    close_token();
    elems_q = elems_q - 64'd1;
    ph_q    = (elems_q == 0) ? PH_DONE : PH_SKIP1;
  endfunction

  function automatic void raise_error(err_e e);
    err_q = e;
    ph_q  = PH_ERROR;
  endfunction

  // one byte of a count or a length; CR ends the number
  function automatic void take_digit(logic [7:0] b, int width, phase_e nxt);
    logic [63:0] lim;
    logic [63:0] v;
    lim = (64'd1 << width) - 64'd1;
    if (b == ChCr) begin
      if (digits_q) ph_q = nxt;
      else raise_error(ERR_NUMBER);
      return;
    end
    if (b < ChZero || b > ChNine) begin
      raise_error(ERR_NUMBER);
      return;
    end
    v = accum_q * 64'd10 + 64'(b - ChZero);
    if (v > lim) begin
      raise_error(ERR_OVERFLOW);
      return;
    end
    accum_q  = v;
    digits_q = 1'b1;
  endfunction

  // queue up every result that one accepted byte causes
  function automatic void tokenize_byte(logic [7:0] b, bit last);
    bit lead_star;
    step_n = 0;
    if (ph_q == PH_START) ph_q = (b == ChStar) ? PH_COUNT : PH_INLINE;
    // a star before any digit of the count is swallowed, the first one too
    lead_star = (ph_q == PH_COUNT) && (b == ChStar) && (accum_q == 0) && !digits_q &&
                (elems_q == 0) && (tokens_q == 0) && (payload_q == 0) &&
                (err_q == ERR_NONE) && !open_q;
    if (lead_star && !last) return;
    if (!lead_star) begin
      case (ph_q)
        PH_INLINE: begin
          if (b == ChSpace || (b >= ChTab && b <= ChCr)) begin
            if (open_q) close_token();
          end else begin
            add_result(KIND_BYTE, b, ERR_NONE);
            open_q = 1'b1;
          end
        end
        PH_COUNT: take_digit(b, CountWidth, PH_COUNT_LF);
        PH_COUNT_LF: begin
          if (b != ChLf) begin
            raise_error(ERR_NUMBER);
          end else begin
            elems_q  = accum_q;
            accum_q  = '0;
            digits_q = 1'b0;
            ph_q     = (elems_q == 0) ? PH_DONE : PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (b == ChDollar) ph_q = PH_LEN;
          else raise_error(ERR_DOLLAR);
        end
        PH_LEN: take_digit(b, LengthWidth, PH_LEN_LF);
        PH_LEN_LF: begin
          if (b != ChLf) begin
            raise_error(ERR_NUMBER);
          end else begin
            payload_q = accum_q;
            accum_q   = '0;
            digits_q  = 1'b0;
            if (payload_q == 0) close_element();
            else ph_q = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          add_result(KIND_BYTE, b, ERR_NONE);
          open_q    = 1'b1;
          payload_q = payload_q - 64'd1;
          if (payload_q == 0) close_element();
        end
        PH_SKIP1: ph_q = PH_SKIP2;
        PH_SKIP2: ph_q = PH_DOLLAR;
        default: ;
      endcase
    end
    if (last) begin
      if (err_q != ERR_NONE) begin
        add_result(KIND_ERR, 8'd0, err_q);
      end else if (ph_q == PH_INLINE) begin
        if (open_q) close_token();
        add_result(KIND_OK, 8'd0, ERR_NONE);
      end else if (ph_q == PH_DONE) begin
        add_result(KIND_OK, 8'd0, ERR_NONE);
      end else begin
        add_result(KIND_ERR, 8'd0, ERR_TRUNC);
      end
      clear_parse();
    end
    if (step_n > 0) step_res[step_n-1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++)
      pending_results.insert(pending_results.size(), step_res[i]);
  endfunction

  initial clear_parse();

  // --------------------------------------------------------------------------
  // reporting and result check
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PrintCap)
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
        if (m_axis_tdata[7:0] !== want.data)
          report_mismatch("data", 32'(m_axis_tdata[7:0]), 32'(want.data));
        if (m_axis_tdata[23:8] !== want.token_index)
          report_mismatch("token_index", 32'(m_axis_tdata[23:8]), 32'(want.token_index));
        if (m_axis_tdata[26:24] !== want.error_code)
          report_mismatch("error_code", 32'(m_axis_tdata[26:24]), 32'(want.error_code));
        if (m_axis_tdata[31:27] !== 5'd0)
          report_mismatch("tdata pad", 32'(m_axis_tdata[31:27]), 32'd0);
        if (m_axis_tlast !== want.run_last)
          report_mismatch("run_last", 32'(m_axis_tlast), 32'(want.run_last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL resp_command_tokenizer_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sink: stall pattern switches between open, random and mostly stalled
  // --------------------------------------------------------------------------
  int rdy_mode = 0;
  int rdy_left = 0;

  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(8, 60);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // source: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(logic [7:0] b, bit last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tokenize_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_request(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // stop the source until every pending result has come out
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // message builders
  // --------------------------------------------------------------------------
  function automatic void append_byte(logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void put_crlf();
    append_byte(ChCr);
    append_byte(ChLf);
  endfunction

  function automatic void put_number(logic [63:0] v);
    if ($urandom_range(0, 9) == 0) append_byte(ChZero);
    put_text($sformatf("%0d", v));
  endfunction

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic void build_array_message();
    logic [63:0] n;
    int made;
    int plen;
    msg_bytes.delete();
    append_byte(ChStar);
    if ($urandom_range(0, 15) == 0) append_byte(ChStar);
    case ($urandom_range(0, 19))
      0:       n = 64'd65535;
      1:       n = 64'd65536 + 64'($urandom_range(0, 1000));
      default: n = 64'($urandom_range(0, 3));
    endcase
    put_number(n);
    put_crlf();
    // a huge count is only partly sent, so it ends early
    made = (n > 4) ? 2 : int'(n);
    for (int e = 0; e < made; e++) begin
      append_byte(ChDollar);
      case ($urandom_range(0, 24))
        0:       n = 64'hFFFF_FFFF;
        1:       n = 64'h1_0000_0000 + 64'($urandom);
        default: n = 64'($urandom_range(0, 5));
      endcase
      put_number(n);
      put_crlf();
      plen = (n > 6) ? $urandom_range(0, 6) : int'(n);
      for (int i = 0; i < plen; i++) append_byte(payload_byte());
      // the skip pair after the final element may be left out
      if (e < made - 1 || $urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          put_crlf();
        end else begin
          append_byte(8'($urandom_range(0, 255)));
          append_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) append_byte(payload_byte());
  endfunction

  function automatic void corrupt_message();
    int pos;
    pos = $urandom_range(0, msg_bytes.size() - 1);
    case ($urandom_range(0, 2))
      0: msg_bytes[pos] = 8'($urandom_range(0, 255));
      1: if (msg_bytes.size() > 1) msg_bytes.delete(pos);
      default: while (msg_bytes.size() > pos + 1) void'(msg_bytes.pop_back());
    endcase
  endfunction

  function automatic void build_inline_message();
    int k;
    msg_bytes.delete();
    repeat ($urandom_range(1, 14)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          k = $urandom_range(0, 6);
          append_byte((k == 6) ? ChSpace : 8'(ChTab + k));
        end
        2:       append_byte(8'($urandom_range(0, 255)));
        default: append_byte(8'($urandom_range(8'h41, 8'h5A)));
      endcase
    end
    if (msg_bytes[0] == ChStar) msg_bytes[0] = 8'h41;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_array_forms();
    // zero-length element closes at its LF, final skip pair left out
    msg_bytes.delete();
    put_text("*1"); put_crlf(); put_text("$0"); put_crlf();
    send_message();
    // empty array with a trailing byte that is ignored
    msg_bytes.delete();
    put_text("*0"); put_crlf(); append_byte(8'hA5);
    send_message();
  endtask

  task automatic test_array_errors();
    // element without dollar
    msg_bytes.delete();
    put_text("*1"); put_crlf(); put_text("#");
    send_message();
    // count overflow, later digit ignored since the first error wins
    msg_bytes.delete();
    put_text("*700001");
    send_message();
    // empty number
    msg_bytes.delete();
    append_byte(ChStar); append_byte(ChCr);
    send_message();
    // CR followed by something other than LF
    msg_bytes.delete();
    put_text("*2"); append_byte(ChCr); put_text("x");
    send_message();
    // message ends before the elements
    msg_bytes.delete();
    put_text("*1");
    send_message();
  endtask

  task automatic test_inline_forms();
    // lowest and highest byte, token still open at the end
    msg_bytes.delete();
    append_byte(8'h00); append_byte(ChSpace); append_byte(8'hFF);
    send_message();
  endtask

  task automatic test_random_messages();
    int start;
    bit paused;
    int pick;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        build_array_message();
        if ($urandom_range(0, 3) == 0) corrupt_message();
      end else if (pick < 9) begin
        build_inline_message();
      end else begin
        msg_bytes.delete();
        append_byte(ChStar);
        repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
      end
      send_message();
      if (!paused && bytes_sent - start >= RandomItems / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_array_forms();
    test_array_errors();
    test_inline_forms();
    settle();
    test_random_messages();
    settle();
    if (pending_results.size() != 0)
      report_mismatch("results never seen", 32'(pending_results.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("PASS resp_command_tokenizer_core");
    end else begin
      $display("FAIL resp_command_tokenizer_core");
    end
    $finish;
  end

endmodule
